FILE: hw/rtl/voxel_time_bin_aggregator_unit_macros.svh
// assertion helpers for the voxel binning block
`ifndef VOXEL_TIME_BIN_AGGREGATOR_UNIT_MACROS_SVH
`define VOXEL_TIME_BIN_AGGREGATOR_UNIT_MACROS_SVH

// same-cycle implication
`define VTBA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define VTBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/vtba_pkg.sv
package vtba_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int DIVN_W = 50;
  localparam int DIVD_W = 34;
  localparam int DCNT_W = $clog2(DIVN_W);

  localparam logic [15:0] SRES_RESET = 16'd1024;
  localparam logic [15:0] TRES_RESET = 16'd16;

  typedef enum logic [1:0] {
    STAT_MORE = 2'd0,
    STAT_LAST = 2'd1,
    STAT_DROP = 2'd2
  } status_e;

  typedef enum logic {
    REG_SRES = 1'b0,
    REG_TRES = 1'b1
  } reg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV_GO,
    S_DIV_WAIT,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_NEW,
    S_DROP,
    S_FL_RD,
    S_FL_CMP,
    S_FL_DRD,
    S_FL_DAT,
    S_MUL,
    S_MUL_ACC,
    S_FRAC_GO,
    S_FRAC_WAIT,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic signed [31:0] bz;
    logic signed [39:0] bt;
    logic signed [31:0] tk;
    logic signed [31:0] ot;
  } key_t;

  typedef struct packed {
    logic [31:0] pdg;
    logic [31:0] fast;
    logic [31:0] slow;
    logic [31:0] elec;
    logic [39:0] energy;
  } data_t;

  localparam int KEY_W  = $bits(key_t);
  localparam int DATA_W = $bits(data_t);

  // flip each field's sign bit so an unsigned compare gives signed lexicographic order
  function automatic logic [KEY_W-1:0] key_ord(key_t k);
    key_t o;
    o       = k;
    o.bx[31] = ~k.bx[31];
    o.by[31] = ~k.by[31];
    o.bz[31] = ~k.bz[31];
    o.bt[39] = ~k.bt[39];
    o.tk[31] = ~k.tk[31];
    o.ot[31] = ~k.ot[31];
    return o;
  endfunction

endpackage

FILE: hw/rtl/vtba_ram.sv
module vtba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/vtba_div.sv
module vtba_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [vtba_pkg::DIVN_W-1:0] dividend_i,
  input  logic [vtba_pkg::DIVD_W-1:0]        divisor_i,
  output logic                               done_o,
  output logic [vtba_pkg::DIVN_W-1:0]        quotient_o
);

  logic                          busy_q;
  logic                          done_q;
  logic [vtba_pkg::DCNT_W-1:0]   cnt_q;
  logic                          neg_q;
  logic [vtba_pkg::DIVN_W-1:0]   quo_q;
  logic [vtba_pkg::DIVD_W-1:0]   rem_q;
  logic [vtba_pkg::DIVD_W-1:0]   div_q;
  logic [vtba_pkg::DIVD_W:0]     rem_sh;
  logic [vtba_pkg::DIVD_W:0]     diff;

  assign rem_sh = {rem_q, quo_q[vtba_pkg::DIVN_W-1]};
  assign diff   = rem_sh - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= vtba_pkg::DCNT_W'(vtba_pkg::DIVN_W - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // restoring divide on the magnitude, one quotient bit per cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[vtba_pkg::DIVN_W-1];
      quo_q <= dividend_i[vtba_pkg::DIVN_W-1] ? -dividend_i : dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      if (!diff[vtba_pkg::DIVD_W]) begin
        rem_q <= diff[vtba_pkg::DIVD_W-1:0];
        quo_q <= {quo_q[vtba_pkg::DIVN_W-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[vtba_pkg::DIVD_W-1:0];
        quo_q <= {quo_q[vtba_pkg::DIVN_W-2:0], 1'b0};
      end
    end
  end

  // floor rounding for negative dividends
  assign quotient_o = !neg_q ? quo_q : ((rem_q != '0) ? ~quo_q : -quo_q);
  assign done_o     = done_q;

endmodule

FILE: hw/rtl/voxel_time_bin_aggregator_unit.sv
// deposit: 4 serial divisions on the shared divider, then a read and compare per stored bin
//   for the key search, ending early on a hit; one transaction at a time
// flush: per bin record a scan of all held bins, then the centre multiplies and the fast
//   fraction divide when photons are present, run in series with the single shared divider
//   and the one-port table reads; a stalled result holds the sequencer
// reset clears the bin count, the emitted marks and the control state at once; resolutions
//   return to 1024 and 16; no clearing pass over the table
module voxel_time_bin_aggregator_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               req_type_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic signed [39:0] time_stamp_i,
  input  logic signed [31:0] track_id_i,
  input  logic signed [31:0] orig_track_id_i,
  input  logic signed [31:0] pdg_code_i,
  input  logic [23:0]        fast_photons_i,
  input  logic [23:0]        slow_photons_i,
  input  logic [23:0]        electron_count_i,
  input  logic [31:0]        energy_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic signed [31:0] centre_x_o,
  output logic signed [31:0] centre_y_o,
  output logic signed [31:0] centre_z_o,
  output logic signed [39:0] centre_t_o,
  output logic signed [31:0] bin_track_o,
  output logic signed [31:0] bin_orig_track_o,
  output logic signed [31:0] bin_pdg_o,
  output logic [31:0]        photon_total_o,
  output logic [31:0]        electron_total_o,
  output logic [39:0]        energy_total_o,
  output logic [16:0]        fast_fraction_o
);

  localparam int DEPTH = vtba_pkg::TABLE_DEPTH;
  localparam int IW    = vtba_pkg::IDX_W;
  localparam int CW    = vtba_pkg::CNT_W;

  vtba_pkg::state_e state_q, state_d;

  logic [15:0]          sres_q, tres_q;
  logic [15:0]          sr;
  logic [19:0]          tr;
  logic [1:0]           field_q;
  logic [CW-1:0]        i_q, cnt_q, k_q;
  logic [DEPTH-1:0]     done_q;
  logic                 have_best_q;
  logic [IW-1:0]        best_idx_q;
  vtba_pkg::key_t       best_key_q, key_q, key_rd;
  vtba_pkg::data_t      ent_data_q, data_rd, data_wr;
  logic [vtba_pkg::KEY_W-1:0]  key_rdata;
  logic [vtba_pkg::DATA_W-1:0] data_rdata;

  logic signed [31:0] x_q, y_q, z_q, tk_q, ot_q, pdg_q;
  logic signed [39:0] t_q;
  logic [23:0]        fast_q, slow_q, elec_q;
  logic [31:0]        en_q;

  logic               acc;
  logic               wr_en, hit, is_last, better;
  logic               key_we, data_we;
  logic [IW-1:0]      raddr, waddr;
  logic               div_start, div_done;
  logic signed [vtba_pkg::DIVN_W-1:0] div_num;
  logic [vtba_pkg::DIVD_W-1:0]        div_den;
  logic [vtba_pkg::DIVN_W-1:0]        div_quo;
  logic [32:0]        tot;
  logic signed [39:0] mul_a;
  logic [20:0]        mul_b;
  logic [19:0]        half;
  logic signed [61:0] mult_q, csum;
  logic [39:0]        cent_c;
  logic [31:0]        sum_fast, sum_slow, sum_elec;
  logic [39:0]        sum_en;

  function automatic logic [31:0] sat32(logic [31:0] a, logic [23:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {9'd0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic logic [39:0] clamp40(logic signed [61:0] v, logic narrow);
    logic signed [61:0] hi, lo;
    hi = narrow ? 62'sd2147483647 : 62'sd549755813887;
    lo = -hi - 62'sd1;
    if (v > hi) return hi[39:0];
    if (v < lo) return lo[39:0];
    return v[39:0];
  endfunction

  assign sr = (sres_q == '0) ? 16'd1 : sres_q;
  assign tr = {((tres_q == '0) ? 16'd1 : tres_q), 4'd0};

  // configuration port
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  always_comb begin
    case (vtba_pkg::reg_e'(paddr[2]))
      vtba_pkg::REG_SRES: prdata = {16'd0, sres_q};
      vtba_pkg::REG_TRES: prdata = {16'd0, tres_q};
      default:            prdata = '0;
    endcase
  end

  assign acc     = in_valid_i && !in_stall_o;
  assign key_rd  = vtba_pkg::key_t'(key_rdata);
  assign data_rd = vtba_pkg::data_t'(data_rdata);
  assign hit     = (key_rd == key_q);
  assign is_last = (status_o == vtba_pkg::STAT_LAST);
  assign better  = !done_q[i_q[IW-1:0]] && (!have_best_q ||
                   (vtba_pkg::key_ord(key_rd) < vtba_pkg::key_ord(best_key_q)));
  assign tot     = {1'b0, ent_data_q.fast} + {1'b0, ent_data_q.slow};

  // table
  vtba_ram #(.WIDTH(vtba_pkg::KEY_W), .DEPTH(DEPTH)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (waddr),
    .wdata_i (key_q),
    .raddr_i (raddr),
    .rdata_o (key_rdata)
  );

  vtba_ram #(.WIDTH(vtba_pkg::DATA_W), .DEPTH(DEPTH)) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (data_we),
    .waddr_i (waddr),
    .wdata_i (data_wr),
    .raddr_i (raddr),
    .rdata_o (data_rdata)
  );

  assign sum_fast = sat32((state_q == vtba_pkg::S_NEW) ? 32'd0 : data_rd.fast, fast_q);
  assign sum_slow = sat32((state_q == vtba_pkg::S_NEW) ? 32'd0 : data_rd.slow, slow_q);
  assign sum_elec = sat32((state_q == vtba_pkg::S_NEW) ? 32'd0 : data_rd.elec, elec_q);
  always_comb begin
    logic [40:0] s;
    s = {1'b0, ((state_q == vtba_pkg::S_NEW) ? 40'd0 : data_rd.energy)} + {9'd0, en_q};
    sum_en = s[40] ? 40'hFF_FFFF_FFFF : s[39:0];
  end
  always_comb begin
    data_wr.pdg    = (state_q == vtba_pkg::S_NEW) ? pdg_q : data_rd.pdg;
    data_wr.fast   = sum_fast;
    data_wr.slow   = sum_slow;
    data_wr.elec   = sum_elec;
    data_wr.energy = sum_en;
  end

  // shared divider: bin indices, then fast fraction
  always_comb begin
    if (state_q == vtba_pkg::S_FRAC_GO) begin
      div_num = {2'b00, ent_data_q.fast, 16'd0};
      div_den = {1'b0, tot};
    end else begin
      case (field_q)
        2'd0:    div_num = {{18{x_q[31]}}, x_q};
        2'd1:    div_num = {{18{y_q[31]}}, y_q};
        2'd2:    div_num = {{18{z_q[31]}}, z_q};
        default: div_num = {{10{t_q[39]}}, t_q};
      endcase
      div_den = (field_q == 2'd3) ? {14'd0, tr} : {18'd0, sr};
    end
  end

  vtba_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // shared multiplier operands for the bin centres
  always_comb begin
    case (field_q)
      2'd0:    mul_a = {{8{best_key_q.bx[31]}}, best_key_q.bx};
      2'd1:    mul_a = {{8{best_key_q.by[31]}}, best_key_q.by};
      2'd2:    mul_a = {{8{best_key_q.bz[31]}}, best_key_q.bz};
      default: mul_a = best_key_q.bt;
    endcase
    mul_b = (field_q == 2'd3) ? {1'b0, tr} : {5'd0, sr};
    half  = (field_q == 2'd3) ? {1'b0, tr[19:1]} : {5'd0, sr[15:1]};
  end
  assign csum   = mult_q + {42'd0, half};
  assign cent_c = clamp40(csum, field_q != 2'd3);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      vtba_pkg::S_IDLE: begin
        if (acc) begin
          if (!req_type_i) state_d = vtba_pkg::S_DIV_GO;
          else if (cnt_q != '0) state_d = vtba_pkg::S_FL_RD;
        end
      end
      vtba_pkg::S_DIV_GO:   state_d = vtba_pkg::S_DIV_WAIT;
      vtba_pkg::S_DIV_WAIT: begin
        if (div_done) begin
          state_d = (field_q == 2'd3) ? vtba_pkg::S_SRCH_RD : vtba_pkg::S_DIV_GO;
        end
      end
      vtba_pkg::S_SRCH_RD: begin
        if (i_q == cnt_q) begin
          state_d = (cnt_q == CW'(DEPTH)) ? vtba_pkg::S_DROP : vtba_pkg::S_NEW;
        end else begin
          state_d = vtba_pkg::S_SRCH_CMP;
        end
      end
      vtba_pkg::S_SRCH_CMP: state_d = hit ? vtba_pkg::S_IDLE : vtba_pkg::S_SRCH_RD;
      vtba_pkg::S_NEW:      state_d = vtba_pkg::S_IDLE;
      vtba_pkg::S_DROP:     if (!out_stall_i) state_d = vtba_pkg::S_IDLE;
      vtba_pkg::S_FL_RD: begin
        state_d = (i_q == cnt_q) ? vtba_pkg::S_FL_DRD : vtba_pkg::S_FL_CMP;
      end
      vtba_pkg::S_FL_CMP:   state_d = vtba_pkg::S_FL_RD;
      vtba_pkg::S_FL_DRD:   state_d = vtba_pkg::S_FL_DAT;
      vtba_pkg::S_FL_DAT:   state_d = vtba_pkg::S_MUL;
      vtba_pkg::S_MUL:      state_d = vtba_pkg::S_MUL_ACC;
      vtba_pkg::S_MUL_ACC: begin
        state_d = (field_q == 2'd3) ? vtba_pkg::S_FRAC_GO : vtba_pkg::S_MUL;
      end
      vtba_pkg::S_FRAC_GO: begin
        state_d = (tot == '0) ? vtba_pkg::S_EMIT : vtba_pkg::S_FRAC_WAIT;
      end
      vtba_pkg::S_FRAC_WAIT: if (div_done) state_d = vtba_pkg::S_EMIT;
      vtba_pkg::S_EMIT: begin
        if (!out_stall_i) state_d = is_last ? vtba_pkg::S_IDLE : vtba_pkg::S_FL_RD;
      end
      default: state_d = vtba_pkg::S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall_o  = (state_q != vtba_pkg::S_IDLE);
    out_valid_o = (state_q == vtba_pkg::S_DROP) || (state_q == vtba_pkg::S_EMIT);
    div_start   = (state_q == vtba_pkg::S_DIV_GO) ||
                  ((state_q == vtba_pkg::S_FRAC_GO) && (tot != '0));
    key_we      = (state_q == vtba_pkg::S_NEW);
    data_we     = (state_q == vtba_pkg::S_NEW) || ((state_q == vtba_pkg::S_SRCH_CMP) && hit);
    waddr       = (state_q == vtba_pkg::S_NEW) ? cnt_q[IW-1:0] : i_q[IW-1:0];
    raddr       = (state_q == vtba_pkg::S_FL_DRD) ? best_idx_q : i_q[IW-1:0];
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vtba_pkg::S_IDLE;
      sres_q      <= vtba_pkg::SRES_RESET;
      tres_q      <= vtba_pkg::TRES_RESET;
      field_q     <= '0;
      i_q         <= '0;
      cnt_q       <= '0;
      k_q         <= '0;
      done_q      <= '0;
      have_best_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (wr_en) begin
        case (vtba_pkg::reg_e'(paddr[2]))
          vtba_pkg::REG_SRES: sres_q <= pwdata[15:0];
          vtba_pkg::REG_TRES: tres_q <= pwdata[15:0];
          default: ;
        endcase
      end
      case (state_q)
        vtba_pkg::S_IDLE: begin
          field_q     <= '0;
          i_q         <= '0;
          k_q         <= '0;
          have_best_q <= 1'b0;
        end
        vtba_pkg::S_DIV_WAIT: if (div_done) field_q <= field_q + 2'd1;
        vtba_pkg::S_SRCH_CMP: i_q <= i_q + 1'b1;
        vtba_pkg::S_NEW:      cnt_q <= cnt_q + 1'b1;
        vtba_pkg::S_FL_CMP: begin
          if (better) have_best_q <= 1'b1;
          i_q <= i_q + 1'b1;
        end
        vtba_pkg::S_FL_DAT: begin
          done_q[best_idx_q] <= 1'b1;
          field_q            <= '0;
        end
        vtba_pkg::S_MUL_ACC: field_q <= field_q + 2'd1;
        vtba_pkg::S_EMIT: begin
          if (!out_stall_i) begin
            i_q         <= '0;
            have_best_q <= 1'b0;
            k_q         <= k_q + 1'b1;
            if (is_last) begin
              cnt_q  <= '0;
              done_q <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    case (state_q)
      vtba_pkg::S_IDLE: begin
        if (acc) begin
          x_q    <= pos_x_i;
          y_q    <= pos_y_i;
          z_q    <= pos_z_i;
          t_q    <= time_stamp_i;
          tk_q   <= track_id_i;
          ot_q   <= orig_track_id_i;
          pdg_q  <= pdg_code_i;
          fast_q <= fast_photons_i;
          slow_q <= slow_photons_i;
          elec_q <= electron_count_i;
          en_q   <= energy_i;
        end
      end
      vtba_pkg::S_DIV_WAIT: begin
        if (div_done) begin
          key_q.tk <= tk_q;
          key_q.ot <= ot_q;
          case (field_q)
            2'd0:    key_q.bx <= div_quo[31:0];
            2'd1:    key_q.by <= div_quo[31:0];
            2'd2:    key_q.bz <= div_quo[31:0];
            default: key_q.bt <= div_quo[39:0];
          endcase
        end
      end
      vtba_pkg::S_SRCH_RD: begin
        status_o         <= vtba_pkg::STAT_DROP;
        centre_x_o       <= '0;
        centre_y_o       <= '0;
        centre_z_o       <= '0;
        centre_t_o       <= '0;
        bin_track_o      <= '0;
        bin_orig_track_o <= '0;
        bin_pdg_o        <= '0;
        photon_total_o   <= '0;
        electron_total_o <= '0;
        energy_total_o   <= '0;
        fast_fraction_o  <= '0;
      end
      vtba_pkg::S_FL_CMP: begin
        if (better) begin
          best_key_q <= key_rd;
          best_idx_q <= i_q[IW-1:0];
        end
      end
      vtba_pkg::S_FL_DAT: begin
        ent_data_q       <= data_rd;
        status_o         <= ((k_q + 1'b1) == cnt_q) ? vtba_pkg::STAT_LAST
                                                    : vtba_pkg::STAT_MORE;
        bin_track_o      <= best_key_q.tk;
        bin_orig_track_o <= best_key_q.ot;
        bin_pdg_o        <= data_rd.pdg;
        electron_total_o <= data_rd.elec;
        energy_total_o   <= data_rd.energy;
      end
      vtba_pkg::S_MUL: mult_q <= mul_a * $signed({1'b0, mul_b});
      vtba_pkg::S_MUL_ACC: begin
        case (field_q)
          2'd0:    centre_x_o <= cent_c[31:0];
          2'd1:    centre_y_o <= cent_c[31:0];
          2'd2:    centre_z_o <= cent_c[31:0];
          default: centre_t_o <= cent_c;
        endcase
      end
      vtba_pkg::S_FRAC_GO: begin
        photon_total_o <= tot[32] ? 32'hFFFF_FFFF : tot[31:0];
        if (tot == '0) fast_fraction_o <= 17'h1_0000;
      end
      vtba_pkg::S_FRAC_WAIT: if (div_done) fast_fraction_o <= div_quo[16:0];
      default: ;
    endcase
  end

endmodule

FILE: hw/rtl/vtba_checker.sv
`include "voxel_time_bin_aggregator_unit_macros.svh"

module vtba_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  status_o,
  input logic [31:0] photon_total_o,
  input logic [39:0] energy_total_o,
  input logic [16:0] fast_fraction_o
);

  `VTBA_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "result dropped while stalled")
  `VTBA_ASSERT_NOW(a_busy_out, out_valid_o, in_stall_o, "input taken while a result is pending")
  `VTBA_ASSERT_NOW(a_drop_zero, out_valid_o && (status_o == vtba_pkg::STAT_DROP), (photon_total_o == 32'd0) && (energy_total_o == 40'd0), "drop report carries data")
  `VTBA_ASSERT_NOW(a_frac_rng, out_valid_o, fast_fraction_o <= 17'h1_0000, "fast fraction above one")

endmodule

bind voxel_time_bin_aggregator_unit vtba_checker u_vtba_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .status_o        (status_o),
  .photon_total_o  (photon_total_o),
  .energy_total_o  (energy_total_o),
  .fast_fraction_o (fast_fraction_o)
);

FILE: tb/voxel_time_bin_aggregator_unit_tb.sv
module voxel_time_bin_aggregator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT = 2000000;
  localparam int SETTLE = 3000;
  localparam int HOLD = 4000;

  typedef struct packed {
    logic               req;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [39:0] ts;
    logic signed [31:0] trk;
    logic signed [31:0] otrk;
    logic signed [31:0] pdg;
    logic [23:0]        fast;
    logic [23:0]        slow;
    logic [23:0]        elec;
    logic [31:0]        en;
  } deposit_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic signed [39:0] ct;
    logic signed [31:0] trk;
    logic signed [31:0] otrk;
    logic signed [31:0] pdg;
    logic [31:0]        photons;
    logic [31:0]        elec;
    logic [39:0]        en;
    logic [16:0]        frac;
  } bin_rec_t;

  typedef struct packed {
    deposit_t d;
    logic     typed;
    bin_rec_t r;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  deposit_t drv = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  bin_rec_t got;

  voxel_time_bin_aggregator_unit uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .req_type_i(drv.req), .pos_x_i(drv.px), .pos_y_i(drv.py), .pos_z_i(drv.pz),
    .time_stamp_i(drv.ts), .track_id_i(drv.trk), .orig_track_id_i(drv.otrk),
    .pdg_code_i(drv.pdg), .fast_photons_i(drv.fast), .slow_photons_i(drv.slow),
    .electron_count_i(drv.elec), .energy_i(drv.en),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .status_o(got.status), .centre_x_o(got.cx), .centre_y_o(got.cy),
    .centre_z_o(got.cz), .centre_t_o(got.ct), .bin_track_o(got.trk),
    .bin_orig_track_o(got.otrk), .bin_pdg_o(got.pdg),
    .photon_total_o(got.photons), .electron_total_o(got.elec),
    .energy_total_o(got.en), .fast_fraction_o(got.frac)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  bin_rec_t pending_bins[$];
  int errors = 0;
  int mismatches = 0;
  int cycles = 0;
  int snd_idle = 0;
  int rcv_idle = 0;
  int hold_cnt = 0;
  bit hold_start = 0;

  logic [15:0] sres = vtba_pkg::SRES_RESET;
  logic [15:0] tres = vtba_pkg::TRES_RESET;
  int n_bins = 0;
  longint kx[vtba_pkg::TABLE_DEPTH], ky[vtba_pkg::TABLE_DEPTH];
  longint kz[vtba_pkg::TABLE_DEPTH], kt[vtba_pkg::TABLE_DEPTH];
  longint ktrk[vtba_pkg::TABLE_DEPTH], kotrk[vtba_pkg::TABLE_DEPTH];
  longint kpdg[vtba_pkg::TABLE_DEPTH];
  longint sfast[vtba_pkg::TABLE_DEPTH], sslow[vtba_pkg::TABLE_DEPTH];
  longint selec[vtba_pkg::TABLE_DEPTH], sen[vtba_pkg::TABLE_DEPTH];

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    bin_rec_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_bins.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("unexpected transaction %p", got);
      end else begin
        e = pending_bins.pop_front();
        if (e.status != got.status || e.cx != got.cx || e.cy != got.cy ||
            e.cz != got.cz || e.ct != got.ct || e.trk != got.trk ||
            e.otrk != got.otrk || e.pdg != got.pdg || e.photons != got.photons ||
            e.elec != got.elec || e.en != got.en || e.frac != got.frac) begin
          errors++;
          if (mismatches++ < 10) $display("mismatch exp %p got %p", e, got);
        end
      end
    end
  end

  // receiver stall, with a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_start) begin
      hold_cnt = HOLD;
      hold_start = 0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < rcv_idle);
    end
  end

  function automatic longint floor_div(longint a, longint d);
    longint q;
    q = a / d;
    if ((a % d) != 0 && a < 0) q--;
    return q;
  endfunction

  function automatic longint clamp_w(longint v, int w);
    longint hi;
    hi = (longint'(1) <<< (w - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic longint sat_w(longint a, longint b, int w);
    longint lim;
    lim = (longint'(1) <<< w) - 1;
    return (a + b > lim) ? lim : a + b;
  endfunction

  function automatic bit key_less(int a, int b);
    longint ka[6];
    longint kb[6];
    ka = '{kx[a], ky[a], kz[a], kt[a], ktrk[a], kotrk[a]};
    kb = '{kx[b], ky[b], kz[b], kt[b], ktrk[b], kotrk[b]};
    for (int i = 0; i < 6; i++) begin
      if (ka[i] < kb[i]) return 1;
      if (ka[i] > kb[i]) return 0;
    end
    return 0;
  endfunction

  task automatic bin_deposit(deposit_t d, bit typed, bin_rec_t tv);
    longint sr, tr, bx, by, bz, bt, tot;
    int hit, best;
    bit done[vtba_pkg::TABLE_DEPTH];
    bin_rec_t r;
    bin_rec_t res[$];
    sr = (sres == 0) ? 1 : longint'(sres);
    tr = ((tres == 0) ? 1 : longint'(tres)) * 16;
    if (d.req) begin
      for (int i = 0; i < vtba_pkg::TABLE_DEPTH; i++) done[i] = 0;
      for (int k = 0; k < n_bins; k++) begin
        best = -1;
        for (int i = 0; i < n_bins; i++)
          if (!done[i] && (best < 0 || key_less(i, best))) best = i;
        done[best] = 1;
        tot = sfast[best] + sslow[best];
        r.status = (k + 1 == n_bins) ? vtba_pkg::STAT_LAST : vtba_pkg::STAT_MORE;
        r.cx = 32'(clamp_w(kx[best] * sr + sr / 2, 32));
        r.cy = 32'(clamp_w(ky[best] * sr + sr / 2, 32));
        r.cz = 32'(clamp_w(kz[best] * sr + sr / 2, 32));
        r.ct = 40'(clamp_w(kt[best] * tr + tr / 2, 40));
        r.trk = 32'(ktrk[best]);
        r.otrk = 32'(kotrk[best]);
        r.pdg = 32'(kpdg[best]);
        r.photons = (tot > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(tot);
        r.elec = 32'(selec[best]);
        r.en = 40'(sen[best]);
        r.frac = (tot == 0) ? 17'd65536 : 17'((sfast[best] <<< 16) / tot);
        res = {res, r};
      end
      n_bins = 0;
    end else begin
      bx = floor_div(longint'(d.px), sr);
      by = floor_div(longint'(d.py), sr);
      bz = floor_div(longint'(d.pz), sr);
      bt = floor_div(longint'(d.ts), tr);
      hit = -1;
      for (int i = 0; i < n_bins; i++)
        if (hit < 0 && kx[i] == bx && ky[i] == by && kz[i] == bz && kt[i] == bt &&
            ktrk[i] == longint'(d.trk) && kotrk[i] == longint'(d.otrk)) hit = i;
      if (hit < 0 && n_bins >= vtba_pkg::TABLE_DEPTH) begin
        r = '0;
        r.status = vtba_pkg::STAT_DROP;
        res = {res, r};
      end else begin
        if (hit < 0) begin
          hit = n_bins++;
          kx[hit] = bx; ky[hit] = by; kz[hit] = bz; kt[hit] = bt;
          ktrk[hit] = d.trk; kotrk[hit] = d.otrk; kpdg[hit] = d.pdg;
          sfast[hit] = 0; sslow[hit] = 0; selec[hit] = 0; sen[hit] = 0;
        end
        sfast[hit] = sat_w(sfast[hit], d.fast, 32);
        sslow[hit] = sat_w(sslow[hit], d.slow, 32);
        selec[hit] = sat_w(selec[hit], d.elec, 32);
        sen[hit] = sat_w(sen[hit], d.en, 40);
      end
    end
    if (typed) pending_bins = {pending_bins, tv};
    else pending_bins = {pending_bins, res};
  endtask

  task automatic send(deposit_t d, bit typed = 0, bin_rec_t tv = '0);
    while ($urandom_range(99) < snd_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    drv <= d;
    do @(posedge clk_i); while (in_stall_o);
    bin_deposit(d, typed, tv);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_bins.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic reg_write(vtba_pkg::reg_e idx, logic [15:0] v);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= {16'h0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == vtba_pkg::REG_SRES) sres = v;
    else tres = v;
  endtask

  function automatic deposit_t rand_deposit();
    deposit_t d;
    d.req = ($urandom_range(24) == 0);
    d.px = ($urandom_range(5) == 0) ? $urandom : int'($urandom_range(6000)) - 3000;
    d.py = ($urandom_range(5) == 0) ? $urandom : int'($urandom_range(6000)) - 3000;
    d.pz = ($urandom_range(5) == 0) ? $urandom : int'($urandom_range(6000)) - 3000;
    d.ts = ($urandom_range(5) == 0) ? 40'({$urandom, $urandom}) :
           40'(longint'($urandom_range(20000)) - 10000);
    d.trk = ($urandom_range(9) == 0) ? $urandom : int'($urandom_range(2)) - 1;
    d.otrk = ($urandom_range(9) == 0) ? $urandom : int'($urandom_range(1));
    d.pdg = $urandom;
    d.fast = ($urandom_range(7) == 0) ? 24'hFF_FFFF : 24'($urandom);
    d.slow = ($urandom_range(7) == 0) ? 24'h0 : 24'($urandom);
    d.elec = 24'($urandom);
    d.en = $urandom;
    return d;
  endfunction

  task automatic fill_table(bit press);
    deposit_t d;
    send('{req: 1'b1, default: '0});
    for (int i = 0; i < vtba_pkg::TABLE_DEPTH + 3; i++) begin
      d = rand_deposit();
      d.req = 1'b0;
      d.trk = i;
      if (press && i == vtba_pkg::TABLE_DEPTH - 2) hold_start = 1;
      send(d);
    end
    send('{req: 1'b1, default: '0});
  endtask

  row_t dir_rows[] = '{
    '{'{req: 1'b1, default: '0}, 1'b0, '0},
    '{'{1'b0, 32'sd0, 32'sd0, 32'sd0, 40'sd0, 32'sd5, 32'sd6, 32'sd11,
        24'd0, 24'd0, 24'd3, 32'd7}, 1'b0, '0},
    '{'{req: 1'b1, default: '0}, 1'b1,
      '{vtba_pkg::STAT_LAST, 32'sd512, 32'sd512, 32'sd512, 40'sd128, 32'sd5, 32'sd6,
        32'sd11, 32'd0, 32'd3, 40'd7, 17'd65536}},
    '{'{1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 40'h7F_FFFF_FFFF,
        32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'hFF_FFFF, 24'h0,
        24'hFF_FFFF, 32'hFFFF_FFFF}, 1'b0, '0},
    '{'{1'b0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 40'h80_0000_0000,
        32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 24'h0, 24'hFF_FFFF,
        24'h0, 32'h0}, 1'b0, '0},
    '{'{1'b0, -32'sd1, -32'sd1025, 32'sd1023, -40'sd1, 32'sd0, -32'sd1, 32'sd22,
        24'd100, 24'd300, 24'd1, 32'd1}, 1'b0, '0},
    '{'{1'b0, -32'sd1024, -32'sd2048, 32'sd0, -40'sd256, 32'sd0, -32'sd1, 32'sd33,
        24'hFF_FFFF, 24'hFF_FFFF, 24'd9, 32'd5}, 1'b0, '0},
    '{'{1'b0, 32'sd1024, 32'sd0, 32'sd0, 40'sd255, 32'sd0, -32'sd1, 32'sd44,
        24'd1, 24'd2, 24'd3, 32'd4}, 1'b0, '0},
    '{'{1'b0, 32'sd1024, 32'sd0, 32'sd0, 40'sd256, 32'sd0, -32'sd1, 32'sd55,
        24'd0, 24'd7, 24'd0, 32'd0}, 1'b0, '0},
    '{'{1'b1, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 40'hFF_FFFF_FFFF,
        32'h0, 32'h0, 32'h0, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF,
        32'hFFFF_FFFF}, 1'b0, '0},
    '{'{req: 1'b1, default: '0}, 1'b0, '0}
  };

  initial begin
    deposit_t d;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    snd_idle = 37;
    rcv_idle = 47;
    foreach (dir_rows[i]) send(dir_rows[i].d, dir_rows[i].typed, dir_rows[i].r);
    settle();

    reg_write(vtba_pkg::REG_SRES, 16'd1);
    reg_write(vtba_pkg::REG_TRES, 16'd65535);
    for (int i = 0; i < 20; i++) send(rand_deposit());
    fill_table(1);
    settle();

    snd_idle = 47;
    rcv_idle = 37;
    reg_write(vtba_pkg::REG_SRES, 16'd65535);
    reg_write(vtba_pkg::REG_TRES, 16'd0);
    for (int i = 0; i < 20; i++) send(rand_deposit());
    send('{req: 1'b1, default: '0});
    settle();
    reg_write(vtba_pkg::REG_SRES, 16'd0);
    reg_write(vtba_pkg::REG_TRES, 16'd1);
    for (int i = 0; i < 30; i++) send(rand_deposit());
    send('{req: 1'b1, default: '0});
    settle();

    snd_idle = 0;
    rcv_idle = 0;
    reg_write(vtba_pkg::REG_SRES, 16'($urandom_range(65535, 1)));
    reg_write(vtba_pkg::REG_TRES, 16'($urandom_range(65535, 1)));
    d = '{1'b0, 32'sd0, 32'sd0, 32'sd0, 40'sd0, 32'sd7, 32'sd7, 32'sd1,
          24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 32'hFFFF_FFFF};
    for (int i = 0; i < 258; i++) send(d);
    send('{req: 1'b1, default: '0});
    for (int i = 0; i < 30; i++) send(rand_deposit());
    send('{req: 1'b1, default: '0});
    settle();

    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
